### rtl/h2e_pkg.sv
// Shared types, constants and CORDIC helpers for the pose-to-Euler core.
package h2e_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int ANG_TAB_LEN  = 24;
    localparam int CW           = 28;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QW           = 2;
    localparam int IN_W         = 176;
    localparam int OUT_W        = 144;
    localparam int THR_W        = 30;

    localparam logic [0:0] REG_GIMBAL_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_SWAP_YAW_ROLL    = 1'b1;

    localparam logic [THR_W-1:0]     THR_RESET   = 30'd26844;
    localparam logic signed [CW-1:0] HALF_PI_Z   = 28'sd26353589;
    localparam logic signed [15:0]   HALF_PI_OUT = 16'sd12868;
    localparam logic signed [17:0]   PI_OUT      = 18'sd25736;
    localparam logic signed [17:0]   GAIN_Q16    = 18'sd107922;

    localparam logic signed [CW-1:0] ANG_TAB [ANG_TAB_LEN] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 zero;
    } t_cv;

    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
    } t_pos;

    typedef struct packed {
        t_pos                 pos;
        logic signed [16:0]   ay;
        logic signed [16:0]   ax;
        logic signed [15:0]   ry;
        logic signed [15:0]   rx;
        logic signed [CW-1:0] ny;
        logic                 lock;
        logic                 pdown;
    } t_job;

    typedef struct packed {
        t_pos                 pos;
        logic signed [CW-1:0] ny;
        logic                 lock;
        logic                 pdown;
        logic signed [15:0]   yaw;
        logic signed [15:0]   roll;
    } t_pl;

    function automatic t_cv cordic_init(input logic signed [CW-1:0] y,
                                        input logic signed [CW-1:0] x);
        t_cv v;
        v.zero = (x == '0) && (y == '0);
        v.x    = x;
        v.y    = y;
        v.z    = '0;
        if (x < 0) begin
            if (y >= 0) begin
                v.x = y;
                v.y = -x;
                v.z = HALF_PI_Z;
            end else begin
                v.x = -y;
                v.y = x;
                v.z = -HALF_PI_Z;
            end
        end
        return v;
    endfunction

    function automatic t_cv cordic_step(input t_cv v, input int i);
        t_cv                  r;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        xs     = v.x >>> i;
        ys     = v.y >>> i;
        r.zero = v.zero;
        if (v.y >= 0) begin
            r.x = v.x + ys;
            r.y = v.y - xs;
            r.z = v.z + ANG_TAB[i[4:0]];
        end else begin
            r.x = v.x - ys;
            r.y = v.y + xs;
            r.z = v.z - ANG_TAB[i[4:0]];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] cordic_round(input t_cv v);
        logic signed [CW:0]    zr;
        logic signed [CW-11:0] q;
        zr = {v.z[CW-1], v.z} + (CW+1)'(1024);
        q  = zr[CW:11];
        if (v.zero)
            return '0;
        if (q > PI_OUT)
            return 16'(PI_OUT);
        if (q < -PI_OUT)
            return 16'(-PI_OUT);
        return 16'(q);
    endfunction

endpackage

### rtl/homogeneous_matrix_to_euler_zyx_core.sv
// Pose matrix to Z-Y-X Euler angles: top level with configuration registers.
// Takes one pose per cycle unless the job queue is full and returns one result per pose, in
// order. A pose passes through a front-end register for squares, with classification on the way
// into the job queue, the queue, the fully pipelined yaw/roll CORDIC lanes followed by the pitch
// CORDIC lane, which needs the yaw magnitude, and the output register. The four-entry queue lets
// the input keep flowing during an output stall until the queue is full.
module homogeneous_matrix_to_euler_zyx_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wen,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [h2e_pkg::THR_W-1:0]   i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // m00, m10, m20, m21, m22, trans_x, trans_y, trans_z
    input  logic [h2e_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // pos_x, pos_y, pos_z, yaw_angle, pitch_angle, roll_angle
    output logic [h2e_pkg::OUT_W-1:0]   m_axis_tdata,
    // gimbal_lock
    output logic [0:0]                  m_axis_tuser
);

    logic [h2e_pkg::THR_W-1:0] r_thr;
    logic                      r_swap;

    logic          push, full, q_valid, pop;
    h2e_pkg::t_job f_job, q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= h2e_pkg::THR_RESET;
            r_swap <= 1'b0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                h2e_pkg::REG_GIMBAL_THRESHOLD: r_thr  <= i_cfg_wdata;
                h2e_pkg::REG_SWAP_YAW_ROLL:    r_swap <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    h2e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_thr   (r_thr),
        .i_full  (full),
        .o_push  (push),
        .o_job   (f_job)
    );

    h2e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    h2e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .i_swap  (r_swap),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_lock  (m_axis_tuser[0])
    );

endmodule

### rtl/h2e_front.sv
// Front end: squares, gimbal classification and operand selection.
module h2e_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [h2e_pkg::IN_W-1:0]    i_data,
    input  logic [h2e_pkg::THR_W-1:0]   i_thr,
    input  logic                        i_full,
    output logic                        o_push,
    output h2e_pkg::t_job               o_job
);

    logic signed [15:0] m00, m10, m20, m21, m22;
    logic signed [16:0] n20;

    logic               r_v;
    logic [31:0]        r_sq00, r_sq10, r_sq21, r_sq22;
    logic signed [34:0] r_prod;
    logic signed [15:0] r_m00, r_m10, r_m20, r_m21, r_m22;
    h2e_pkg::t_pos      r_pos;

    logic [31:0]        s0, s1;
    logic signed [34:0] nyr;

    assign m00 = i_data[15:0];
    assign m10 = i_data[31:16];
    assign m20 = i_data[47:32];
    assign m21 = i_data[63:48];
    assign m22 = i_data[79:64];
    assign n20 = -{m20[15], m20};

    assign o_ready = !r_v || !i_full;
    assign o_push  = r_v && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_sq00 <= 32'(m00 * m00);
            r_sq10 <= 32'(m10 * m10);
            r_sq21 <= 32'(m21 * m21);
            r_sq22 <= 32'(m22 * m22);
            r_prod <= 35'(n20 * h2e_pkg::GAIN_Q16);
            r_m00  <= m00;
            r_m10  <= m10;
            r_m20  <= m20;
            r_m21  <= m21;
            r_m22  <= m22;
            r_pos.tx <= i_data[111:80];
            r_pos.ty <= i_data[143:112];
            r_pos.tz <= i_data[175:144];
        end
    end

    always_comb begin
        s0  = r_sq00 + r_sq10;
        s1  = r_sq21 + r_sq22;
        nyr = (r_prod + 35'sd128) >>> 8;
        o_job.pos   = r_pos;
        o_job.lock  = (s0 <= {2'b00, i_thr}) || (s1 <= {2'b00, i_thr});
        o_job.pdown = (r_m20 > 0);
        o_job.ny    = h2e_pkg::CW'(nyr);
        o_job.ry    = r_m21;
        o_job.rx    = r_m22;
        if (!o_job.lock) begin
            o_job.ay = {r_m10[15], r_m10};
            o_job.ax = {r_m00[15], r_m00};
        end else if (o_job.pdown) begin
            o_job.ay = -{r_m21[15], r_m21};
            o_job.ax = -{r_m20[15], r_m20};
        end else begin
            o_job.ay = {r_m21[15], r_m21};
            o_job.ax = {r_m20[15], r_m20};
        end
    end

endmodule

### rtl/h2e_queue.sv
// Short job queue between the front end and the CORDIC back end.
module h2e_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  h2e_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output h2e_pkg::t_job o_job
);

    h2e_pkg::t_job              r_mem [h2e_pkg::QUEUE_DEPTH];
    logic [h2e_pkg::QW-1:0]     r_wr, r_rd;
    logic [h2e_pkg::QW:0]       r_cnt;
    logic                       pop;

    assign o_full  = (r_cnt == (h2e_pkg::QW+1)'(h2e_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wr <= r_wr + 1'b1;
            if (pop)
                r_rd <= r_rd + 1'b1;
            if (i_push && !pop)
                r_cnt <= r_cnt + 1'b1;
            else if (!i_push && pop)
                r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_job;
    end

endmodule

### rtl/h2e_back.sv
// Back end: pipelined CORDIC lanes for yaw, roll and pitch, plus output register.
module h2e_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  h2e_pkg::t_job             i_job,
    output logic                      o_pop,
    input  logic                      i_swap,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [h2e_pkg::OUT_W-1:0] o_data,
    output logic                      o_lock
);

    localparam int N = h2e_pkg::CORDIC_STEPS;
    localparam int L = 2 * N + 1;

    h2e_pkg::t_cv r_a [0:N];
    h2e_pkg::t_cv r_r [0:N];
    h2e_pkg::t_cv r_p [0:N];
    h2e_pkg::t_pl r_pl [0:L];
    logic         r_v [0:L];

    logic               r_ov;
    h2e_pkg::t_pos      r_opos;
    logic signed [15:0] r_oyaw, r_opitch, r_oroll;
    logic               r_olock;

    logic               en;
    logic signed [h2e_pkg::CW-1:0] ay, ax, ry, rx;
    logic signed [15:0] f_yaw, f_pitch, f_roll;

    assign en    = !r_ov || i_ready;
    assign o_pop = en;

    assign ay = h2e_pkg::CW'($signed({i_job.ay, 8'b0}));
    assign ax = h2e_pkg::CW'($signed({i_job.ax, 8'b0}));
    assign ry = h2e_pkg::CW'($signed({i_job.ry, 8'b0}));
    assign rx = h2e_pkg::CW'($signed({i_job.rx, 8'b0}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= L; k++)
                r_v[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= L; k++)
                r_v[k] <= r_v[k-1];
            r_ov <= r_v[L];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a[0]       <= h2e_pkg::cordic_init(ay, ax);
            r_r[0]       <= h2e_pkg::cordic_init(ry, rx);
            r_pl[0].pos   <= i_job.pos;
            r_pl[0].ny    <= i_job.ny;
            r_pl[0].lock  <= i_job.lock;
            r_pl[0].pdown <= i_job.pdown;
            r_pl[0].yaw   <= '0;
            r_pl[0].roll  <= '0;

            r_p[0]           <= h2e_pkg::cordic_init(r_pl[N].ny, r_a[N].x);
            r_pl[N+1].pos    <= r_pl[N].pos;
            r_pl[N+1].ny     <= r_pl[N].ny;
            r_pl[N+1].lock   <= r_pl[N].lock;
            r_pl[N+1].pdown  <= r_pl[N].pdown;
            r_pl[N+1].yaw    <= h2e_pkg::cordic_round(r_a[N]);
            r_pl[N+1].roll   <= h2e_pkg::cordic_round(r_r[N]);
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_a[k]      <= h2e_pkg::cordic_step(r_a[k-1], k - 1);
                r_r[k]      <= h2e_pkg::cordic_step(r_r[k-1], k - 1);
                r_pl[k]     <= r_pl[k-1];
                r_p[k]      <= h2e_pkg::cordic_step(r_p[k-1], k - 1);
                r_pl[N+1+k] <= r_pl[N+k];
            end
        end
    end

    always_comb begin
        f_yaw = r_pl[L].yaw;
        if (r_pl[L].lock) begin
            f_roll  = '0;
            f_pitch = r_pl[L].pdown ? -h2e_pkg::HALF_PI_OUT : h2e_pkg::HALF_PI_OUT;
        end else begin
            f_roll  = r_pl[L].roll;
            f_pitch = h2e_pkg::cordic_round(r_p[N]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_opos   <= r_pl[L].pos;
            r_opitch <= f_pitch;
            r_olock  <= r_pl[L].lock;
            r_oyaw   <= i_swap ? f_roll : f_yaw;
            r_oroll  <= i_swap ? f_yaw : f_roll;
        end
    end

    assign o_valid = r_ov;
    assign o_lock  = r_olock;
    assign o_data  = {r_oroll, r_opitch, r_oyaw, r_opos.tz, r_opos.ty, r_opos.tx};

endmodule

### rtl/h2e_checker.sv
// Port-level checks for the pose-to-Euler core, bound to the top level.
module h2e_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [h2e_pkg::OUT_W-1:0]   m_axis_tdata,
    input logic [0:0]                  m_axis_tuser
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled output transaction changed");

    a_lock_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[127:112] == 16'd12868) || (m_axis_tdata[127:112] == 16'hCDBC))
        else $error("gimbal lock without quarter-turn pitch");

    a_lock_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[143:128] == 16'd0) || (m_axis_tdata[111:96] == 16'd0))
        else $error("gimbal lock without a zero angle");

endmodule

bind homogeneous_matrix_to_euler_zyx_core h2e_checker u_h2e_checker (.*);
